// ===== hdl/pfa_pkg.sv =====
// shared constants, codes and control structs for the page frame allocator
// no dependencies; every other file imports this package
package pfa_pkg;

    localparam int NUM_FRAMES_DEF = 64;

    localparam int MODE_W    = 3;
    localparam int FRAME_W   = 6;
    localparam int OWNER_W   = 8;
    localparam int STAMP_W   = 32;
    localparam int RND_W     = 16;
    localparam int PAGES_W   = 7;
    localparam int CNT_OUT_W = 7;

    localparam logic [PAGES_W-1:0] PAGES_RST = 7'd64;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC     = 3'd0,
        MODE_FREE      = 3'd1,
        MODE_TEST      = 3'd2,
        MODE_EVICT_RND = 3'd3,
        MODE_EVICT_LRU = 3'd4,
        MODE_TOUCH     = 3'd5
    } t_mode;

    // sample strobe and accumulator clear for the scan unit
    typedef struct packed {
        logic clr;
        logic vld;
    } t_scan_ctl;

    // write strobes toward the owner and stamp stores
    typedef struct packed {
        logic stamp_we;
        logic owner_we;
    } t_store_wr;

endpackage

// ===== hdl/pfa_if.sv =====
// valid/ready channel interfaces for the request and response items
// depends on pfa_pkg for field widths
interface pfa_req_if import pfa_pkg::*;;
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [FRAME_W-1:0] frame;
    logic [OWNER_W-1:0] owner;
    logic [STAMP_W-1:0] stamp;
    logic [RND_W-1:0]   random_value;

    modport source (output valid, mode, frame, owner, stamp, random_value, input ready);
    modport sink   (input valid, mode, frame, owner, stamp, random_value, output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [FRAME_W-1:0]   frame_index;
    logic                 ok;
    logic                 is_used;
    logic [OWNER_W-1:0]   victim_owner;
    logic [CNT_OUT_W-1:0] free_count;

    modport source (output valid, frame_index, ok, is_used, victim_owner, free_count,
                    input ready);
    modport sink   (input valid, frame_index, ok, is_used, victim_owner, free_count,
                    output ready);
endinterface

// ===== hdl/pfa_mod.sv =====
// iterative remainder unit, one quotient bit per cycle (restoring)
// depends on pfa_pkg
module pfa_mod import pfa_pkg::*; #(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [RND_W-1:0]                      i_dividend,
    input  logic [$clog2(NUM_FRAMES+1)-1:0]       i_divisor,
    output logic                                  o_done,
    output logic [$clog2(NUM_FRAMES)-1:0]         o_rem
);
    localparam int FW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int SW = $clog2(RND_W);

    logic          r_busy;
    logic [SW-1:0] r_step;
    logic [RND_W-1:0] r_dvd;
    logic [CW-1:0] r_dvs;
    logic [CW-1:0] r_rem;
    logic [CW:0]   rem_sh;
    logic [CW:0]   rem_sub;
    logic [CW-1:0] n_rem;

    assign rem_sh  = {r_rem, r_dvd[RND_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign n_rem   = (rem_sh >= {1'b0, r_dvs}) ? rem_sub[CW-1:0] : rem_sh[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= SW'(RND_W - 1);
        end else if (r_busy) begin
            r_step <= r_step - SW'(1);
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = !r_busy;
    assign o_rem  = r_rem[FW-1:0];

    // partial remainder stays below the divisor on every step
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dvs))
        else $error("remainder reached divisor");

endmodule

// ===== hdl/pfa_store.sv =====
// per-frame owner and stamp stores, registered reads
// depends on pfa_pkg; stamp entries read as zero until first touched
module pfa_store import pfa_pkg::*; #(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_store_wr                         i_wr,
    input  logic [$clog2(NUM_FRAMES)-1:0]     i_stamp_waddr,
    input  logic [STAMP_W-1:0]                i_stamp_wdata,
    input  logic [$clog2(NUM_FRAMES)-1:0]     i_stamp_raddr,
    output logic [STAMP_W-1:0]                o_stamp_rdata,
    input  logic [$clog2(NUM_FRAMES)-1:0]     i_owner_waddr,
    input  logic [OWNER_W-1:0]                i_owner_wdata,
    input  logic [$clog2(NUM_FRAMES)-1:0]     i_owner_raddr,
    output logic [OWNER_W-1:0]                o_owner_rdata
);
    logic [STAMP_W-1:0]    r_stamp_mem [NUM_FRAMES];
    logic [OWNER_W-1:0]    r_owner_mem [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] r_stamp_vld;
    logic [STAMP_W-1:0]    r_stamp_rd;
    logic                  r_stamp_rd_vld;
    logic [OWNER_W-1:0]    r_owner_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp_vld <= '0;
        end else if (i_wr.stamp_we) begin
            r_stamp_vld[i_stamp_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.stamp_we) begin
            r_stamp_mem[i_stamp_waddr] <= i_stamp_wdata;
        end
        r_stamp_rd     <= r_stamp_mem[i_stamp_raddr];
        r_stamp_rd_vld <= r_stamp_vld[i_stamp_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.owner_we) begin
            r_owner_mem[i_owner_waddr] <= i_owner_wdata;
        end
        r_owner_rd <= r_owner_mem[i_owner_raddr];
    end

    assign o_stamp_rdata = r_stamp_rd_vld ? r_stamp_rd : '0;
    assign o_owner_rdata = r_owner_rd;

endmodule

// ===== hdl/pfa_scan.sv =====
// shared scan unit: free count, first free frame and oldest stamp, one frame a cycle
// depends on pfa_pkg
module pfa_scan import pfa_pkg::*; #(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_scan_ctl                           i_ctl,
    input  logic [$clog2(NUM_FRAMES)-1:0]       i_idx,
    input  logic                                i_used,
    input  logic [STAMP_W-1:0]                  i_stamp,
    output logic [$clog2(NUM_FRAMES+1)-1:0]     o_free_cnt,
    output logic                                o_ff_vld,
    output logic [$clog2(NUM_FRAMES)-1:0]       o_ff_idx,
    output logic [$clog2(NUM_FRAMES)-1:0]       o_min_idx
);
    localparam int FW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);

    logic [CW-1:0]      r_cnt;
    logic               r_ff_vld;
    logic [FW-1:0]      r_ff_idx;
    logic               r_min_vld;
    logic [STAMP_W-1:0] r_min_stamp;
    logic [FW-1:0]      r_min_idx;
    logic               take_min;

    // strict compare keeps the lowest index on equal stamps
    assign take_min = !r_min_vld || (i_stamp < r_min_stamp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_cnt     <= '0;
            r_ff_vld  <= 1'b0;
            r_min_vld <= 1'b0;
        end else if (i_ctl.vld) begin
            if (!i_used) begin
                r_cnt    <= r_cnt + CW'(1);
                r_ff_vld <= 1'b1;
            end
            r_min_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            if (!i_used && !r_ff_vld) begin
                r_ff_idx <= i_idx;
            end
            if (take_min) begin
                r_min_stamp <= i_stamp;
                r_min_idx   <= i_idx;
            end
        end
    end

    assign o_free_cnt = r_cnt;
    assign o_ff_vld   = r_ff_vld;
    assign o_ff_idx   = r_ff_idx;
    assign o_min_idx  = r_min_idx;

    // a first free frame is known exactly when some free frame was counted
    a_ff_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ff_vld == (r_cnt != '0))
        else $error("first free flag disagrees with free count");

endmodule

// ===== hdl/page_frame_allocator_lru_unit.sv =====
// top level of the page frame allocator: sequencer, used bitmap and output register
// depends on pfa_pkg, pfa_if, pfa_mod, pfa_store, pfa_scan
//
//  port        dir   kind             what it moves
//  i_req       in    valid/ready      one request item: mode, frame, owner, stamp, random_value
//  o_rsp       out   valid/ready      one response item per request
//  i_cfg_*     in    write strobe     pages_in_use register, 7 bits
//
// an item passes from accept through the scan, drain, update and result states to response
// valid: the scan walks the n clamped pages one frame a cycle through the shared compare
// unit, and every mode waits in the drain state for the 16-step remainder unit
// i_req.ready is high only while the sequencer is idle; a new item is taken while the
// previous response still waits in the output register
// o_rsp stalls hold the sequencer in its final state until the output register frees
// reset is synchronous and clears the used bitmap and stamp valid bits at once
module page_frame_allocator_lru_unit import pfa_pkg::*; #(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [PAGES_W-1:0] i_cfg_data,
    pfa_req_if.sink            i_req,
    pfa_rsp_if.source          o_rsp
);
    localparam int FW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int OW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
    localparam int NW = (CW > PAGES_W) ? CW : PAGES_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_UPD   = 5'b01000,
        S_RES   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // config register
    logic [PAGES_W-1:0] r_pages;

    // latched request
    logic [MODE_W-1:0]  r_mode;
    logic [FRAME_W-1:0] r_frame;
    logic [OWNER_W-1:0] r_owner;
    logic [STAMP_W-1:0] r_stamp;
    logic [CW-1:0]      r_n;

    // scan issue and aligned sample
    logic [CW-1:0] r_i;
    logic          r_sv;
    logic [FW-1:0] r_sidx;
    logic          r_sused;

    // used bitmap, cleared by reset
    logic [NUM_FRAMES-1:0] r_used;

    // outcome of the update step
    logic [OW-1:0] r_idx;
    logic          r_ok;
    logic          r_alloc_hit;
    logic [CW-1:0] r_cnt;

    // output register
    logic                 r_ovld;
    logic [FRAME_W-1:0]   r_o_idx;
    logic                 r_o_ok;
    logic                 r_o_used;
    logic [OWNER_W-1:0]   r_o_vown;
    logic [CNT_OUT_W-1:0] r_o_cnt;

    logic          accept;
    logic [NW-1:0] pages_x;
    logic [CW-1:0] n_cur;
    logic [OW-1:0] frame_x;
    logic [FW-1:0] frame_ix;
    logic          frame_in;

    t_scan_ctl     scan_ctl;
    logic [CW-1:0] scan_cnt;
    logic          scan_ff_vld;
    logic [FW-1:0] scan_ff_idx;
    logic [FW-1:0] scan_min_idx;
    logic [STAMP_W-1:0] stamp_rd;
    logic [OWNER_W-1:0] owner_rd;
    logic          mod_done;
    logic [FW-1:0] mod_rem;

    // update step decisions
    t_store_wr     st_wr;
    logic [OW-1:0] upd_idx;
    logic          upd_ok;
    logic [CW-1:0] upd_cnt;
    logic          upd_clr_used;

    // response assembly
    logic          res_load;
    logic          idx_in;
    logic          res_used;
    logic [OWNER_W-1:0] res_vown;
    logic [OW-1:0] cnt_x;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // page count clamped to 1..NUM_FRAMES
    assign pages_x = NW'(r_pages);
    assign n_cur   = (pages_x == '0) ? CW'(1)
                   : (pages_x > NW'(NUM_FRAMES)) ? CW'(NUM_FRAMES)
                   : pages_x[CW-1:0];

    assign frame_x  = OW'(r_frame);
    assign frame_ix = frame_x[FW-1:0];
    assign frame_in = frame_x < OW'(r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages <= PAGES_RST;
        end else if (i_cfg_we) begin
            r_pages <= i_cfg_data;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_i == r_n - CW'(1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (mod_done) n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_RES;
            end
            S_RES: begin
                if (res_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sv    <= (r_state == S_SCAN);
        end
    end

    // request latch and scan index
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_req.mode;
            r_frame <= i_req.frame;
            r_owner <= i_req.owner;
            r_stamp <= i_req.stamp;
            r_n     <= n_cur;
            r_i     <= '0;
        end else if (r_state == S_SCAN) begin
            r_i <= r_i + CW'(1);
        end
        // used bit travels alongside the registered stamp read
        r_sidx  <= r_i[FW-1:0];
        r_sused <= r_used[r_i[FW-1:0]];
    end

    assign scan_ctl.clr = accept;
    assign scan_ctl.vld = r_sv;

    // update step: pick the frame, apply the state change, adjust the free count
    always_comb begin
        upd_idx      = frame_x;
        upd_ok       = 1'b0;
        upd_cnt      = scan_cnt;
        upd_clr_used = 1'b0;
        st_wr        = '0;
        case (r_mode)
            MODE_ALLOC: begin
                if (scan_ff_vld) begin
                    upd_idx        = OW'(scan_ff_idx);
                    upd_ok         = 1'b1;
                    upd_cnt        = scan_cnt - CW'(1);
                    st_wr.owner_we = 1'b1;
                end
            end
            MODE_FREE: begin
                if (frame_in) begin
                    upd_ok       = 1'b1;
                    upd_clr_used = 1'b1;
                    if (r_used[frame_ix]) upd_cnt = scan_cnt + CW'(1);
                end
            end
            MODE_TEST: begin
                upd_ok = frame_in;
            end
            MODE_EVICT_RND: begin
                upd_idx = OW'(mod_rem);
                upd_ok  = 1'b1;
            end
            MODE_EVICT_LRU: begin
                upd_idx = OW'(scan_min_idx);
                upd_ok  = 1'b1;
            end
            MODE_TOUCH: begin
                if (frame_in) begin
                    upd_ok         = 1'b1;
                    st_wr.stamp_we = 1'b1;
                end
            end
            default: begin
                upd_ok = 1'b0;
            end
        endcase
        if (r_state != S_UPD) begin
            st_wr        = '0;
            upd_clr_used = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            if (st_wr.owner_we) r_used[scan_ff_idx] <= 1'b1;
            if (upd_clr_used)   r_used[frame_ix]    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_idx       <= upd_idx;
            r_ok        <= upd_ok;
            r_cnt       <= upd_cnt;
            r_alloc_hit <= st_wr.owner_we;
        end
    end

    // response: used flag after the update, owner only for a used frame
    assign idx_in   = r_idx < OW'(r_n);
    assign res_used = idx_in && r_used[r_idx[FW-1:0]];
    assign res_vown = !res_used   ? '0
                    : r_alloc_hit ? r_owner
                    : owner_rd;
    assign cnt_x    = OW'(r_cnt);
    assign res_load = (r_state == S_RES) && (!r_ovld || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (res_load) begin
            r_ovld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_o_idx  <= r_idx[FRAME_W-1:0];
            r_o_ok   <= r_ok;
            r_o_used <= res_used;
            r_o_vown <= res_vown;
            r_o_cnt  <= cnt_x[CNT_OUT_W-1:0];
        end
    end

    assign o_rsp.valid        = r_ovld;
    assign o_rsp.frame_index  = r_o_idx;
    assign o_rsp.ok           = r_o_ok;
    assign o_rsp.is_used      = r_o_used;
    assign o_rsp.victim_owner = r_o_vown;
    assign o_rsp.free_count   = r_o_cnt;

    pfa_mod #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (i_req.random_value),
        .i_divisor  (n_cur),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    pfa_store #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (st_wr),
        .i_stamp_waddr (frame_ix),
        .i_stamp_wdata (r_stamp),
        .i_stamp_raddr (r_i[FW-1:0]),
        .o_stamp_rdata (stamp_rd),
        .i_owner_waddr (scan_ff_idx),
        .i_owner_wdata (r_owner),
        .i_owner_raddr (upd_idx[FW-1:0]),
        .o_owner_rdata (owner_rd)
    );

    pfa_scan #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_idx      (r_sidx),
        .i_used     (r_sused),
        .i_stamp    (stamp_rd),
        .o_free_cnt (scan_cnt),
        .o_ff_vld   (scan_ff_vld),
        .o_ff_idx   (scan_ff_idx),
        .o_min_idx  (scan_min_idx)
    );

    // an accepted item always starts a scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN))
        else $error("accepted item did not start a scan");

    // free count never exceeds the managed page count
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES) |-> (r_cnt <= r_n))
        else $error("free count above page count");

    // a successful alloc leaves its frame marked used
    a_alloc_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES && r_alloc_hit) |-> res_used)
        else $error("allocated frame not marked used");

endmodule
